// File: rtl/bti_pkg.sv
// Shared types, codes and constants of the bilinear table interpolator.
`timescale 1ns / 1ps
package bti_pkg;

  // Input item codes.
  localparam logic [1:0] MODE_ROW_BP = 2'd0;
  localparam logic [1:0] MODE_COL_BP = 2'd1;
  localparam logic [1:0] MODE_TABLE  = 2'd2;
  localparam logic [1:0] MODE_QUERY  = 2'd3;

  // Configuration register indexes and reset values.
  localparam logic [1:0] CFG_ROW_USED   = 2'd0;
  localparam logic [1:0] CFG_COL_USED   = 2'd1;
  localparam logic [4:0] ROW_USED_RESET = 5'd8;
  localparam logic [4:0] COL_USED_RESET = 5'd11;

  // Default grid size.
  localparam int DEF_ROW_POINTS_MAX = 16;
  localparam int DEF_COL_POINTS_MAX = 16;

  // Fraction precision: one quotient bit per divider step.
  localparam int FRAC_BITS = 16;

  // Blend operand selects.
  localparam logic [1:0] SEL_LO  = 2'd0;
  localparam logic [1:0] SEL_HI  = 2'd1;
  localparam logic [1:0] SEL_ROW = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       wr_en;
    logic       q_load;
    logic       srch_run;
    logic       bp_lo;
    logic       bp_hi;
    logic       frac;
    logic       div_init;
    logic       div_step;
    logic       tab_rd;
    logic [1:0] tab_sel;
    logic       mul;
    logic       add;
    logic [1:0] bsel;
  } bti_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic srch_done;
  } bti_stat_t;

endpackage

// File: rtl/bti_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/bti_div.sv
// Restoring fraction divider: floor(num * 2^16 / den), clamped to 0..1.
`timescale 1ns / 1ps
module bti_div import bti_pkg::*; (
  input  logic                 clk,
  input  logic                 init,
  input  logic                 step,
  input  logic signed [32:0]   num,
  input  logic signed [32:0]   den,
  output logic [FRAC_BITS:0]   quot
);

  logic [33:0]          rem_r;
  logic [FRAC_BITS-1:0] q_r;
  logic                 zero_r;
  logic                 one_r;
  logic [33:0]          rem2;
  logic [33:0]          den_u;
  logic                 fits;

  assign rem2  = {rem_r[32:0], 1'b0};
  assign den_u = {1'b0, den};
  assign fits  = rem2 >= den_u;

  // One quotient bit per step; special cases are decided at init.
  always_ff @(posedge clk) begin
    if (init) begin
      zero_r <= (den <= 33'sd0) || (num <= 33'sd0);
      one_r  <= num >= den;
      rem_r  <= {1'b0, num};
      q_r    <= '0;
    end else if (step) begin
      rem_r <= fits ? (rem2 - den_u) : rem2;
      q_r   <= {q_r[FRAC_BITS-2:0], fits};
    end
  end

  always_comb begin
    if (zero_r) begin
      quot = '0;
    end else if (one_r) begin
      quot = {1'b1, {FRAC_BITS{1'b0}}};
    end else begin
      quot = {1'b0, q_r};
    end
  end

endmodule

// File: rtl/bti_dp.sv
// Datapath: breakpoint and table memories, cell search, fractions and blends.
`timescale 1ns / 1ps
module bti_dp import bti_pkg::*; #(
  parameter int ROW_POINTS_MAX = DEF_ROW_POINTS_MAX,
  parameter int COL_POINTS_MAX = DEF_COL_POINTS_MAX
) (
  input  logic        clk,
  input  logic        rst_n,
  input  bti_cmd_t    cmd,
  output bti_stat_t   stat,
  input  logic [1:0]  in_mode,
  input  logic [3:0]  in_row_index,
  input  logic [3:0]  in_col_index,
  input  logic [31:0] in_value_a,
  input  logic [31:0] in_value_b,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  output logic [31:0] out_first_value,
  output logic [31:0] out_second_value,
  output logic [3:0]  out_row_cell,
  output logic [3:0]  out_col_cell
);

  localparam int RAW  = $clog2(ROW_POINTS_MAX);
  localparam int CAW  = $clog2(COL_POINTS_MAX);
  localparam int TDEP = ROW_POINTS_MAX * COL_POINTS_MAX;
  localparam int TAW  = $clog2(TDEP);
  localparam int PMAX = (ROW_POINTS_MAX > COL_POINTS_MAX) ? ROW_POINTS_MAX : COL_POINTS_MAX;
  localparam int KW   = $clog2(PMAX + 1);

  logic [4:0]           row_used_r, col_used_r;
  logic [KW-1:0]        nr, nc, k_r, m;
  logic                 row_done_r, col_done_r;
  logic [RAW-1:0]       row_cell_r, row_raddr;
  logic [CAW-1:0]       col_cell_r, col_raddr;
  logic [31:0]          qa_r, qb_r, row_rd, col_rd, row_lo_r, col_lo_r;
  logic signed [32:0]   row_d_r, row_s_r, col_d_r, col_s_r;
  logic [FRAC_BITS:0]   tr, tc;
  logic                 row_we, col_we, tab_we, row_hit, col_hit;
  logic [TAW-1:0]       tab_waddr, tab_raddr;
  logic [63:0]          tab_rd;
  logic                 rd_vld_r;
  logic [1:0]           rd_sel_r;
  logic [3:0][63:0]     tv_r;
  logic [1:0][31:0]     lo_r, hi_r, outv_r, a_m, b_m, res;
  logic [1:0][FRAC_BITS:0] t_m;
  logic signed [32:0]   diff [2];
  logic signed [50:0]   prod [2];
  logic signed [50:0]   prod_r [2];
  logic signed [50:0]   rnd [2];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_used_r <= ROW_USED_RESET;
      col_used_r <= COL_USED_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_ROW_USED) begin
        row_used_r <= cfg_data;
      end else if (cfg_index == CFG_COL_USED) begin
        col_used_r <= cfg_data;
      end
    end
  end

  // Points in use, clamped to the axis limits.
  always_comb begin
    if (row_used_r < 5'd2) begin
      nr = KW'(2);
    end else if (int'(row_used_r) > ROW_POINTS_MAX) begin
      nr = KW'(ROW_POINTS_MAX);
    end else begin
      nr = KW'(row_used_r);
    end
    if (col_used_r < 5'd2) begin
      nc = KW'(2);
    end else if (int'(col_used_r) > COL_POINTS_MAX) begin
      nc = KW'(COL_POINTS_MAX);
    end else begin
      nc = KW'(col_used_r);
    end
  end

  // Load writes go straight to the memories in the transfer cycle.
  assign row_we = cmd.wr_en && (in_mode == MODE_ROW_BP) &&
                  (int'(in_row_index) < ROW_POINTS_MAX);
  assign col_we = cmd.wr_en && (in_mode == MODE_COL_BP) &&
                  (int'(in_col_index) < COL_POINTS_MAX);
  assign tab_we = cmd.wr_en && (in_mode == MODE_TABLE) &&
                  (int'(in_row_index) < ROW_POINTS_MAX) &&
                  (int'(in_col_index) < COL_POINTS_MAX);
  assign tab_waddr = TAW'(int'(in_row_index) * COL_POINTS_MAX + int'(in_col_index));

  // Breakpoint read address: search counter, then the lower and upper points.
  always_comb begin
    if (cmd.bp_hi) begin
      row_raddr = row_cell_r + RAW'(1);
      col_raddr = col_cell_r + CAW'(1);
    end else if (cmd.bp_lo) begin
      row_raddr = row_cell_r;
      col_raddr = col_cell_r;
    end else begin
      row_raddr = RAW'(k_r);
      col_raddr = CAW'(k_r);
    end
  end

  bti_ram #(.WIDTH(32), .DEPTH(ROW_POINTS_MAX)) u_row_bp (
    .clk(clk), .we(row_we), .waddr(RAW'(in_row_index)), .wdata(in_value_a),
    .raddr(row_raddr), .rdata(row_rd)
  );

  bti_ram #(.WIDTH(32), .DEPTH(COL_POINTS_MAX)) u_col_bp (
    .clk(clk), .we(col_we), .waddr(CAW'(in_col_index)), .wdata(in_value_a),
    .raddr(col_raddr), .rdata(col_rd)
  );

  // Both tables share one grid, so one memory holds the pair.
  assign tab_raddr = TAW'(int'(row_cell_r) * COL_POINTS_MAX + int'(col_cell_r) +
                          (cmd.tab_sel[0] ? 1 : 0) +
                          (cmd.tab_sel[1] ? COL_POINTS_MAX : 0));

  bti_ram #(.WIDTH(64), .DEPTH(TDEP)) u_table (
    .clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata({in_value_b, in_value_a}),
    .raddr(tab_raddr), .rdata(tab_rd)
  );

  // Search compares the entry addressed in the previous cycle.
  assign m       = k_r - KW'(1);
  assign row_hit = $signed(qa_r) <= $signed(row_rd);
  assign col_hit = $signed(qb_r) <= $signed(col_rd);
  assign stat.srch_done = row_done_r && col_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r        <= '0;
      row_done_r <= 1'b0;
      col_done_r <= 1'b0;
      rd_vld_r   <= 1'b0;
    end else begin
      rd_vld_r <= cmd.tab_rd;
      if (cmd.q_load) begin
        k_r        <= '0;
        row_done_r <= 1'b0;
        col_done_r <= 1'b0;
      end else if (cmd.srch_run && !stat.srch_done) begin
        k_r <= k_r + KW'(1);
        if (k_r != '0) begin
          if (row_hit || (m == nr - KW'(1))) begin
            row_done_r <= 1'b1;
          end
          if (col_hit || (m == nc - KW'(1))) begin
            col_done_r <= 1'b1;
          end
        end
      end
    end
  end

  // Cell capture, following the first-hit rule of the search.
  always_ff @(posedge clk) begin
    if (cmd.q_load) begin
      qa_r <= in_value_a;
      qb_r <= in_value_b;
    end
    if (cmd.srch_run && (k_r != '0)) begin
      if (!row_done_r) begin
        if (row_hit) begin
          row_cell_r <= (m == '0) ? '0 : RAW'(m - KW'(1));
        end else if (m == nr - KW'(1)) begin
          row_cell_r <= RAW'(nr - KW'(2));
        end
      end
      if (!col_done_r) begin
        if (col_hit) begin
          col_cell_r <= (m == '0) ? '0 : CAW'(m - KW'(1));
        end else if (m == nc - KW'(1)) begin
          col_cell_r <= CAW'(nc - KW'(2));
        end
      end
    end
  end

  // Offset and span on both axes.
  always_ff @(posedge clk) begin
    if (cmd.bp_hi) begin
      row_lo_r <= row_rd;
      col_lo_r <= col_rd;
    end
    if (cmd.frac) begin
      row_d_r <= {qa_r[31], qa_r} - {row_lo_r[31], row_lo_r};
      row_s_r <= {row_rd[31], row_rd} - {row_lo_r[31], row_lo_r};
      col_d_r <= {qb_r[31], qb_r} - {col_lo_r[31], col_lo_r};
      col_s_r <= {col_rd[31], col_rd} - {col_lo_r[31], col_lo_r};
    end
  end

  bti_div u_row_div (
    .clk(clk), .init(cmd.div_init), .step(cmd.div_step),
    .num(row_d_r), .den(row_s_r), .quot(tr)
  );

  bti_div u_col_div (
    .clk(clk), .init(cmd.div_init), .step(cmd.div_step),
    .num(col_d_r), .den(col_s_r), .quot(tc)
  );

  // Corner values arrive in the cycle after their address.
  always_ff @(posedge clk) begin
    rd_sel_r <= cmd.tab_sel;
    if (rd_vld_r) begin
      tv_r[rd_sel_r] <= tab_rd;
    end
  end

  // Blend lanes, one per table: v0 + round((v1 - v0) * t / 2^16).
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      unique case (cmd.bsel)
        SEL_LO: begin
          a_m[l] = tv_r[0][32*l +: 32];
          b_m[l] = tv_r[1][32*l +: 32];
          t_m[l] = tc;
        end
        SEL_HI: begin
          a_m[l] = tv_r[2][32*l +: 32];
          b_m[l] = tv_r[3][32*l +: 32];
          t_m[l] = tc;
        end
        SEL_ROW: begin
          a_m[l] = lo_r[l];
          b_m[l] = hi_r[l];
          t_m[l] = tr;
        end
        default: begin
          a_m[l] = '0;
          b_m[l] = '0;
          t_m[l] = '0;
        end
      endcase
      diff[l] = {b_m[l][31], b_m[l]} - {a_m[l][31], a_m[l]};
      prod[l] = diff[l] * $signed({1'b0, t_m[l]});
      rnd[l]  = (prod_r[l] + 51'sd32768) >>> FRAC_BITS;
      res[l]  = a_m[l] + rnd[l][31:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      if (cmd.mul) begin
        prod_r[l] <= prod[l];
      end
      if (cmd.add) begin
        if (cmd.bsel == SEL_LO) begin
          lo_r[l] <= res[l];
        end else if (cmd.bsel == SEL_HI) begin
          hi_r[l] <= res[l];
        end else begin
          outv_r[l] <= res[l];
        end
      end
    end
  end

  assign out_first_value  = outv_r[0];
  assign out_second_value = outv_r[1];
  assign out_row_cell     = 4'(row_cell_r);
  assign out_col_cell     = 4'(col_cell_r);

endmodule

// File: rtl/bti_ctrl.sv
// Controller: sequences search, fraction division, table reads and blends.
`timescale 1ns / 1ps
module bti_ctrl import bti_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_mode,
  input  bti_stat_t  stat,
  output bti_cmd_t   cmd,
  output logic       busy,
  output logic       out_valid
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SRCH  = 4'd1;
  localparam logic [3:0] S_BPLO  = 4'd2;
  localparam logic [3:0] S_BPHI  = 4'd3;
  localparam logic [3:0] S_FRAC  = 4'd4;
  localparam logic [3:0] S_DINIT = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_TAB   = 4'd7;
  localparam logic [3:0] S_M0    = 4'd8;
  localparam logic [3:0] S_A0    = 4'd9;
  localparam logic [3:0] S_M1    = 4'd10;
  localparam logic [3:0] S_A1    = 4'd11;
  localparam logic [3:0] S_M2    = 4'd12;
  localparam logic [3:0] S_A2    = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign busy      = state_r != S_IDLE;
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;

  // Next state and datapath commands.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.wr_en = accept;
        if (accept && (in_mode == MODE_QUERY)) begin
          cmd.q_load = 1'b1;
          state_nxt  = S_SRCH;
        end
      end
      S_SRCH: begin
        cmd.srch_run = 1'b1;
        if (stat.srch_done) begin
          state_nxt = S_BPLO;
        end
      end
      S_BPLO: begin
        cmd.bp_lo = 1'b1;
        state_nxt = S_BPHI;
      end
      S_BPHI: begin
        cmd.bp_hi = 1'b1;
        state_nxt = S_FRAC;
      end
      S_FRAC: begin
        cmd.frac  = 1'b1;
        state_nxt = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 4'd1;
        if (cnt_r == 4'(FRAC_BITS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_TAB;
        end
      end
      S_TAB: begin
        cmd.tab_rd  = 1'b1;
        cmd.tab_sel = cnt_r[1:0];
        cnt_nxt     = cnt_r + 4'd1;
        if (cnt_r == 4'd3) begin
          state_nxt = S_M0;
        end
      end
      S_M0: begin
        cmd.mul   = 1'b1;
        cmd.bsel  = SEL_LO;
        state_nxt = S_A0;
      end
      S_A0: begin
        cmd.add   = 1'b1;
        cmd.bsel  = SEL_LO;
        state_nxt = S_M1;
      end
      S_M1: begin
        cmd.mul   = 1'b1;
        cmd.bsel  = SEL_HI;
        state_nxt = S_A1;
      end
      S_A1: begin
        cmd.add   = 1'b1;
        cmd.bsel  = SEL_HI;
        state_nxt = S_M2;
      end
      S_M2: begin
        cmd.mul   = 1'b1;
        cmd.bsel  = SEL_ROW;
        state_nxt = S_A2;
      end
      S_A2: begin
        cmd.add       = 1'b1;
        cmd.bsel      = SEL_ROW;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/bilinear_table_interpolator.sv
// Top level of the two-axis breakpoint table with bilinear interpolation.
//
//   channel   handshake                 payload
//   input     start / busy              in_mode, in_row_index, in_col_index,
//                                       in_value_a, in_value_b
//   result    out_valid (one cycle)     out_first_value, out_second_value,
//                                       out_row_cell, out_col_cell
//   config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Load items finish in their transfer cycle and leave busy low. A query keeps
// busy high through the linear breakpoint search, the fraction divider, and
// the breakpoint reads, shared table port and blend multipliers. The result
// shows for one cycle right after busy falls; the receiver cannot stall it.
// Reset is synchronous, active low, and restores both point counts.
`timescale 1ns / 1ps
module bilinear_table_interpolator import bti_pkg::*; #(
  parameter int ROW_POINTS_MAX = DEF_ROW_POINTS_MAX,
  parameter int COL_POINTS_MAX = DEF_COL_POINTS_MAX
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [3:0]  in_row_index,
  input  logic [3:0]  in_col_index,
  input  logic [31:0] in_value_a,
  input  logic [31:0] in_value_b,
  output logic        out_valid,
  output logic [31:0] out_first_value,
  output logic [31:0] out_second_value,
  output logic [3:0]  out_row_cell,
  output logic [3:0]  out_col_cell,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  bti_cmd_t  cmd;
  bti_stat_t stat;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  bti_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_mode(in_mode),
    .stat(stat), .cmd(cmd), .busy(busy), .out_valid(out_valid)
  );

  bti_dp #(
    .ROW_POINTS_MAX(ROW_POINTS_MAX),
    .COL_POINTS_MAX(COL_POINTS_MAX)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_mode(in_mode), .in_row_index(in_row_index), .in_col_index(in_col_index),
    .in_value_a(in_value_a), .in_value_b(in_value_b),
    .cfg_valid(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_first_value(out_first_value), .out_second_value(out_second_value),
    .out_row_cell(out_row_cell), .out_col_cell(out_col_cell)
  );

  // Results are single-cycle strobes spaced by a full query.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // Every result closes a busy period.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> $past(busy))
    else $error("result without a query in flight");

  // Only a query transfer makes the block busy.
  assert property (@(posedge clk) disable iff (!rst_n)
      $rose(busy) |-> $past(start && (in_mode == MODE_QUERY)))
    else $error("busy without a query transfer");

endmodule
